// ----- rtl/core/nvdn_pkg.sv -----
// ----------------------------------------------------------------------------
// nvdn_pkg - shared constants, types and sine table
// Fixed-point formats and the quarter-wave sine table used by the normal
// vector decode and normalise pipeline.
// ----------------------------------------------------------------------------
package nvdn_pkg;

  localparam int SINE_BITS   = 10;
  localparam int TAB_LEN     = (1 << SINE_BITS) + 1;
  localparam int IDX_W       = SINE_BITS + 1;
  localparam int PHASE_SHIFT = 16 - SINE_BITS;
  localparam int PHASE_W     = 17;
  localparam int Q30_W       = 31;
  localparam int SQ_W        = 62;
  localparam int ROOT_W      = 31;
  localparam int NQ_W        = 16;
  localparam logic [15:0] SAMPLE_MAX_RESET = 16'd255;
  localparam logic [PHASE_W-1:0] PHASE_FULL = 17'd65536;
  localparam logic [Q30_W-1:0] Q30_ONE = 31'h4000_0000;
  localparam logic [14:0] Q15_MAX = 15'h7fff;

  typedef logic [Q30_W-1:0] sine_tab_t [0:TAB_LEN-1];

  typedef struct packed {
    logic              neg;
    logic [Q30_W-1:0]  mag;
  } nvdn_comp_t;

  function automatic longint qmul(longint a, longint b);
    longint p;
    longint h;
    p = a * b;
    h = longint'(1) << 29;
    if (p >= 0) return (p + h) >>> 30;
    return -((-p + h) >>> 30);
  endfunction

  // odd Taylor series to degree 11, evaluated in Q30
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint x;
    longint x2;
    longint acc;
    for (int i = 0; i < TAB_LEN; i++) begin
      x   = longint'(i) << (30 - SINE_BITS);
      x2  = qmul(x, x);
      acc = -3864;
      acc = 172272 + qmul(acc, x2);
      acc = -5026995 + qmul(acc, x2);
      acc = 85569306 + qmul(acc, x2);
      acc = -693598669 + qmul(acc, x2);
      acc = 1686629713 + qmul(acc, x2);
      acc = qmul(acc, x);
      if (acc < 0) acc = 0;
      if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
      tab[i] = Q30_W'(acc);
    end
    tab[TAB_LEN-1] = Q30_ONE;
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// ----- rtl/core/nvdn_ifs.sv -----
// ----------------------------------------------------------------------------
// nvdn_ifs - channel interfaces
// Pixel sample input, unit normal output and configuration write channels.
// ----------------------------------------------------------------------------
interface nvdn_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_x;
  logic [15:0] sample_y;
  logic [15:0] sample_z;
  modport source (output valid, sample_x, sample_y, sample_z, input ready);
  modport sink (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface nvdn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               zero_length;
  modport source (output valid, normal_x, normal_y, normal_z, zero_length, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, zero_length, output ready);
endinterface

interface nvdn_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_max;
  modport source (output valid, sample_max, input ready);
  modport sink (input valid, sample_max, output ready);
endinterface

// ----- rtl/core/nvdn_phase.sv -----
// ----------------------------------------------------------------------------
// nvdn_phase - sample to quarter-wave phase
// Saturates the sample, folds it about mid-scale and divides by twice the
// maximum with a pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module nvdn_phase (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [15:0]                  sample,
  input  logic [15:0]                  mx,
  output logic                         out_valid,
  output logic [nvdn_pkg::PHASE_W-1:0] phase,
  output logic                         neg
);
  import nvdn_pkg::*;

  localparam int QB = PHASE_W;
  localparam int NW = 16 + PHASE_W + 1;

  logic [15:0]    s_sat;
  logic [16:0]    s2;
  logic [16:0]    mx17;
  logic           is_neg;
  logic [16:0]    mag;
  logic [PHASE_W-1:0] dvs;

  logic           v   [0:QB];
  logic           sg  [0:QB];
  logic [NW-1:0]  rem [0:QB];
  logic [QB-1:0]  q   [0:QB];

  always_comb begin
    s_sat  = (sample > mx) ? mx : sample;
    s2     = {s_sat, 1'b0};
    mx17   = {1'b0, mx};
    is_neg = s2 < mx17;
    mag    = is_neg ? (mx17 - s2) : (s2 - mx17);
    dvs    = {mx, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0]   <= in_valid;
      sg[0]  <= is_neg;
      rem[0] <= (NW'(mag) << PHASE_W) + NW'(mx);
      q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int J = QB - 1 - k;
    logic [NW-1:0] dsh;
    logic          ge;
    always_comb begin
      dsh = NW'(dvs) << J;
      ge  = rem[k] >= dsh;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1]   <= v[k];
        sg[k+1]  <= sg[k];
        rem[k+1] <= ge ? (rem[k] - dsh) : rem[k];
        q[k+1]   <= {q[k][QB-2:0], ge};
      end
    end
  end

  assign out_valid = v[QB];
  assign phase     = (q[QB] > PHASE_FULL) ? PHASE_FULL : q[QB];
  assign neg       = sg[QB];

endmodule

// ----- rtl/core/nvdn_sine.sv -----
// ----------------------------------------------------------------------------
// nvdn_sine - quarter-wave sine lookup with linear interpolation
// Registered reads of two neighbouring table entries, then interpolation.
// ----------------------------------------------------------------------------
module nvdn_sine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [nvdn_pkg::PHASE_W-1:0] phase,
  input  logic                         neg,
  output logic                         out_valid,
  output nvdn_pkg::nvdn_comp_t         comp
);
  import nvdn_pkg::*;

  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       idx_hi;
  logic [PHASE_SHIFT-1:0] fr;

  logic                   va;
  logic                   nega;
  logic [Q30_W-1:0]       lo;
  logic [Q30_W-1:0]       hi;
  logic [PHASE_SHIFT-1:0] fra;

  logic [Q30_W-1:0]             diff;
  logic [Q30_W+PHASE_SHIFT-1:0] prod;
  logic [Q30_W-1:0]             v_int;

  always_comb begin
    idx    = phase[PHASE_W-1:PHASE_SHIFT];
    fr     = phase[PHASE_SHIFT-1:0];
    idx_hi = (idx == IDX_W'(TAB_LEN - 1)) ? idx : idx + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va   <= in_valid;
      nega <= neg;
      fra  <= fr;
      lo   <= SINE_TAB[idx];
      hi   <= SINE_TAB[idx_hi];
    end
  end

  always_comb begin
    diff  = (hi < lo) ? '0 : (hi - lo);
    prod  = (Q30_W+PHASE_SHIFT)'(diff) * (Q30_W+PHASE_SHIFT)'(fra);
    v_int = lo + Q30_W'((prod + (Q30_W+PHASE_SHIFT)'(1 << (PHASE_SHIFT - 1)))
            >> PHASE_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= va;
      comp.neg  <= nega;
      comp.mag  <= v_int;
    end
  end

endmodule

// ----- rtl/core/nvdn_norm_len.sv -----
// ----------------------------------------------------------------------------
// nvdn_norm_len - Euclidean length of the decoded vector
// Squares, sum, then a pipelined digit-by-digit square root, one root bit
// per stage. The components travel alongside so they leave with the length.
// ----------------------------------------------------------------------------
module nvdn_norm_len (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  nvdn_pkg::nvdn_comp_t         comp_in  [0:2],
  output logic                         out_valid,
  output nvdn_pkg::nvdn_comp_t         comp_out [0:2],
  output logic [nvdn_pkg::ROOT_W-1:0]  len
);
  import nvdn_pkg::*;

  localparam int RS = ROOT_W;

  logic             vs;
  nvdn_comp_t       cs  [0:2];
  logic [SQ_W-1:0]  sq  [0:2];

  logic             v    [0:RS];
  nvdn_comp_t       cd   [0:RS][0:2];
  logic [SQ_W-1:0]  rem  [0:RS];
  logic [ROOT_W-1:0] root [0:RS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else if (adv) begin
      vs <= in_valid;
      for (int i = 0; i < 3; i++) begin
        cs[i] <= comp_in[i];
        sq[i] <= SQ_W'(comp_in[i].mag) * SQ_W'(comp_in[i].mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0]    <= vs;
      cd[0]   <= cs;
      rem[0]  <= sq[0] + sq[1] + sq[2];
      root[0] <= '0;
    end
  end

  for (genvar k = 0; k < RS; k++) begin : g_sqrt
    localparam int I = RS - 1 - k;
    logic [63:0] delta;
    logic        ge;
    always_comb begin
      delta = (64'(root[k]) << (I + 1)) + (64'(1) << (2 * I));
      ge    = 64'(rem[k]) >= delta;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1]    <= v[k];
        cd[k+1]   <= cd[k];
        rem[k+1]  <= ge ? (rem[k] - delta[SQ_W-1:0]) : rem[k];
        root[k+1] <= ge ? (root[k] | (ROOT_W'(1) << I)) : root[k];
      end
    end
  end

  assign out_valid = v[RS];
  assign comp_out  = cd[RS];
  assign len       = root[RS];

endmodule

// ----- rtl/core/nvdn_q15_div.sv -----
// ----------------------------------------------------------------------------
// nvdn_q15_div - one component divided by the length into Q1.15
// Rounded pipelined restoring divider, saturate and restore the sign.
// ----------------------------------------------------------------------------
module nvdn_q15_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  nvdn_pkg::nvdn_comp_t         comp,
  input  logic [nvdn_pkg::ROOT_W-1:0]  len,
  output logic                         out_valid,
  output logic signed [15:0]           normal,
  output logic                         zero
);
  import nvdn_pkg::*;

  localparam int QB = NQ_W;
  localparam int NW = Q30_W + 15 + 1;

  logic             v   [0:QB];
  logic             sg  [0:QB];
  logic             zf  [0:QB];
  logic [ROOT_W-1:0] dv [0:QB];
  logic [NW-1:0]    rem [0:QB];
  logic [QB-1:0]    q   [0:QB];

  logic [14:0]      sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0]   <= in_valid;
      sg[0]  <= comp.neg;
      zf[0]  <= len == '0;
      // with a zero length the quotient never reaches the output, any divisor will do
      dv[0]  <= (len == '0) ? ROOT_W'(1) : len;
      rem[0] <= (NW'(comp.mag) << 15) + NW'(len[ROOT_W-1:1]);
      q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int J = QB - 1 - k;
    logic [NW-1:0] dsh;
    logic          ge;
    always_comb begin
      dsh = NW'(dv[k]) << J;
      ge  = rem[k] >= dsh;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1]   <= v[k];
        sg[k+1]  <= sg[k];
        zf[k+1]  <= zf[k];
        dv[k+1]  <= dv[k];
        rem[k+1] <= ge ? (rem[k] - dsh) : rem[k];
        q[k+1]   <= {q[k][QB-2:0], ge};
      end
    end
  end

  assign sat = q[QB][15] ? Q15_MAX : q[QB][14:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[QB];
      zero      <= zf[QB];
      if (zf[QB]) normal <= '0;
      else if (sg[QB]) normal <= -$signed({1'b0, sat});
      else normal <= $signed({1'b0, sat});
    end
  end

endmodule

// ----- rtl/core/normal_vector_decode_normalize.sv -----
// ----------------------------------------------------------------------------
// normal_vector_decode_normalize - decode and normalise an encoded normal
// Turns three raw pixel samples into a unit normal in Q1.15.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  : one transaction per pixel, raw samples sample_x/y/z.
//   normal : one transaction per pixel, normal_x/y/z in Q1.15 and
//            zero_length, in the order the pixels arrived.
//   cfg    : writes sample_max; always ready. Write only while no pixel is
//            in flight.
// From pixel to normal the path runs through the phase divider
// (one quotient bit a stage), the sine table read and interpolation,
// squares, sum and the 31-stage square root, and the
// 16-stage component divider with its output register.
// Throughput is one pixel per cycle while normal is not stalled. The whole pipeline advances together:
// while a result waits on normal and the receiver stalls, every stage
// holds and pixel.ready drops; nothing is lost or repeated.
// Reset empties the pipeline and sets sample_max to 255.
// ----------------------------------------------------------------------------
module normal_vector_decode_normalize (
  input  logic       clk,
  input  logic       rst,
  nvdn_in_if.sink    pixel,
  nvdn_out_if.source normal,
  nvdn_cfg_if.sink   cfg
);
  import nvdn_pkg::*;

  logic        adv;
  logic [15:0] sample_max;
  logic [15:0] mx;

  logic [15:0]        smp   [0:2];
  logic               ph_v  [0:2];
  logic [PHASE_W-1:0] ph    [0:2];
  logic               ph_n  [0:2];
  logic               sn_v  [0:2];
  nvdn_comp_t         comp  [0:2];
  logic               ln_v;
  nvdn_comp_t         comp_d [0:2];
  logic [ROOT_W-1:0]  len;
  logic               dq_v  [0:2];
  logic signed [15:0] nrm   [0:2];
  logic               zr    [0:2];

  assign adv         = !normal.valid || normal.ready;
  assign pixel.ready = adv;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_max <= SAMPLE_MAX_RESET;
    end else if (cfg.valid) begin
      sample_max <= cfg.sample_max;
    end
  end

  assign mx = (sample_max == '0) ? 16'd1 : sample_max;

  assign smp[0] = pixel.sample_x;
  assign smp[1] = pixel.sample_y;
  assign smp[2] = pixel.sample_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    nvdn_phase u_phase (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (pixel.valid),
      .sample    (smp[i]),
      .mx        (mx),
      .out_valid (ph_v[i]),
      .phase     (ph[i]),
      .neg       (ph_n[i])
    );
    nvdn_sine u_sine (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (ph_v[i]),
      .phase     (ph[i]),
      .neg       (ph_n[i]),
      .out_valid (sn_v[i]),
      .comp      (comp[i])
    );
  end

  nvdn_norm_len u_len (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sn_v[0]),
    .comp_in   (comp),
    .out_valid (ln_v),
    .comp_out  (comp_d),
    .len       (len)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    nvdn_q15_div u_div (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (ln_v),
      .comp      (comp_d[i]),
      .len       (len),
      .out_valid (dq_v[i]),
      .normal    (nrm[i]),
      .zero      (zr[i])
    );
  end

  assign normal.valid       = dq_v[0];
  assign normal.normal_x    = nrm[0];
  assign normal.normal_y    = nrm[1];
  assign normal.normal_z    = nrm[2];
  assign normal.zero_length = zr[0];

  a_zero_gives_zeros : assert property (@(posedge clk) disable iff (rst)
    normal.valid && normal.zero_length |->
      normal.normal_x == 16'sd0 && normal.normal_y == 16'sd0 && normal.normal_z == 16'sd0)
    else $error("zero-length result with non-zero components");

  a_no_min_code : assert property (@(posedge clk) disable iff (rst)
    normal.valid |->
      normal.normal_x != -16'sd32768 && normal.normal_y != -16'sd32768 &&
      normal.normal_z != -16'sd32768)
    else $error("normal component outside Q1.15 symmetric range");

  a_unit_not_null : assert property (@(posedge clk) disable iff (rst)
    normal.valid && !normal.zero_length |->
      !(normal.normal_x == 16'sd0 && normal.normal_y == 16'sd0 && normal.normal_z == 16'sd0))
    else $error("non-zero length gave an all-zero normal");

  // the zero flags only mean something once a transaction has arrived
  a_lanes_aligned : assert property (@(posedge clk) disable iff (rst)
    sn_v[0] == sn_v[1] && sn_v[1] == sn_v[2] &&
    dq_v[0] == dq_v[1] && dq_v[1] == dq_v[2] &&
    (!dq_v[0] || (zr[0] == zr[1] && zr[1] == zr[2])))
    else $error("component lanes out of step");

endmodule

// ----- dv/normal_vector_decode_normalize_tb.sv -----
// ----------------------------------------------------------------------------
// normal_vector_decode_normalize_tb - unit normal decode testbench
// Drives pixels through the decode and normalise pipeline under several
// sample_max settings and idle patterns, and checks each normal against a
// bit-accurate fixed-point prediction held in a scoreboard.
// ----------------------------------------------------------------------------
module normal_vector_decode_normalize_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nvdn_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int TAB_BITS       = 10;
  localparam int TAB_SIZE       = (1 << TAB_BITS) + 1;
  localparam int FRAC_SHIFT     = 16 - TAB_BITS;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               zero_len;
  } normal_t;

  class normal_scoreboard;
    normal_t pending_normals[$];
    longint  quarter_sine[TAB_SIZE];
    int      mismatches;

    function new();
      mismatches = 0;
      build_table();
    endfunction

    function longint round_mul(longint a, longint b);
      longint p;
      p = a * b;
      if (p >= 0) return (p + (longint'(1) << 29)) >>> 30;
      return -((-p + (longint'(1) << 29)) >>> 30);
    endfunction

    function void build_table();
      longint x;
      longint x2;
      longint acc;
      for (int i = 0; i < TAB_SIZE; i++) begin
        x   = longint'(i) << (30 - TAB_BITS);
        x2  = round_mul(x, x);
        acc = -3864;
        acc = 172272 + round_mul(acc, x2);
        acc = -5026995 + round_mul(acc, x2);
        acc = 85569306 + round_mul(acc, x2);
        acc = -693598669 + round_mul(acc, x2);
        acc = 1686629713 + round_mul(acc, x2);
        acc = round_mul(acc, x);
        if (acc < 0) acc = 0;
        if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
        quarter_sine[i] = acc;
      end
      quarter_sine[TAB_SIZE-1] = longint'(1) << 30;
    endfunction

    function longint decode_sample(longint s, longint mx);
      longint d;
      longint mag;
      longint ph;
      longint idx;
      longint fr;
      longint lo;
      longint hi;
      longint v;
      d   = 2 * s - mx;
      mag = (d < 0) ? -d : d;
      ph  = (mag * 131072 + mx) / (2 * mx);
      if (ph > 65536) ph = 65536;
      idx = ph >>> FRAC_SHIFT;
      fr  = ph & ((longint'(1) << FRAC_SHIFT) - 1);
      lo  = quarter_sine[idx];
      hi  = (idx + 1 < TAB_SIZE) ? quarter_sine[idx+1] : lo;
      if (hi < lo) hi = lo;
      v = lo + (((hi - lo) * fr + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT);
      return (d < 0) ? -v : v;
    endfunction

    function longint int_sqrt(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    function logic signed [15:0] to_q15(longint c, longint m);
      longint mag;
      longint q;
      mag = (c < 0) ? -c : c;
      q   = (mag * 32768 + m / 2) / m;
      if (q > 32767) q = 32767;
      return 16'((c < 0) ? -q : q);
    endfunction

    function void note_pixel(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                             logic [15:0] smax);
      longint  mx;
      longint  comp[3];
      longint  raw[3];
      longint unsigned sum;
      longint  m;
      normal_t n;
      mx = (smax == 0) ? 1 : smax;
      raw[0] = sx;
      raw[1] = sy;
      raw[2] = sz;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        if (raw[k] > mx) raw[k] = mx;
        comp[k] = decode_sample(raw[k], mx);
        sum = sum + longint'(comp[k] * comp[k]);
      end
      m = int_sqrt(sum);
      if (m == 0) begin
        n = '{nx: 0, ny: 0, nz: 0, zero_len: 1'b1};
      end else begin
        n.nx = to_q15(comp[0], m);
        n.ny = to_q15(comp[1], m);
        n.nz = to_q15(comp[2], m);
        n.zero_len = 1'b0;
      end
      pending_normals.push_back(n);
    endfunction

    function void check_normal(normal_t got);
      normal_t want;
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected normal %p", got);
        return;
      end
      want = pending_normals.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("normal mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                   want.nx, want.ny, want.nz, want.zero_len,
                   got.nx, got.ny, got.nz, got.zero_len);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  nvdn_in_if  pixel_ch ();
  nvdn_out_if normal_ch ();
  nvdn_cfg_if cfg_ch ();

  normal_vector_decode_normalize dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel_ch.sink),
    .normal (normal_ch.source),
    .cfg    (cfg_ch.sink)
  );

  normal_scoreboard board = new();
  logic [15:0] active_max = SAMPLE_MAX_RESET;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    pixel_ch.valid    = 1'b0;
    pixel_ch.sample_x = '0;
    pixel_ch.sample_y = '0;
    pixel_ch.sample_z = '0;
    normal_ch.ready   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.sample_max = '0;
  end

  // receiver side: stall at random, check every normal transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (normal_ch.valid && normal_ch.ready)
        board.check_normal('{nx: normal_ch.normal_x, ny: normal_ch.normal_y,
                             nz: normal_ch.normal_z, zero_len: normal_ch.zero_length});
      normal_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((pixel_ch.valid && pixel_ch.ready) || (normal_ch.valid && normal_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // valid stays high between back-to-back transactions; drop it only to idle
  task automatic send_pixel(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid    <= 1'b1;
    pixel_ch.sample_x <= sx;
    pixel_ch.sample_y <= sy;
    pixel_ch.sample_z <= sz;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
    board.note_pixel(sx, sy, sz, active_max);
  endtask

  task automatic write_max(logic [15:0] value);
    pixel_ch.valid <= 1'b0;
    while (board.pending_normals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.sample_max <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    active_max = value;
  endtask

  // mostly in range, sometimes above the maximum or at the edges
  function automatic logic [15:0] pick_sample(logic [15:0] mx);
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'($urandom);
    if (r < 14) return 16'd0;
    if (r < 20) return mx;
    if (r < 24) return mx >> 1;
    return 16'($urandom_range(mx));
  endfunction

  logic [15:0] max_plan[8] = '{16'd255, 16'd1, 16'd65535, 16'd0, 16'd2,
                               16'd1023, 16'd3, 16'd40000};

  initial begin
    logic [15:0] h;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: near-centre, extremes, axes, above maximum; a maximum of 2 later puts the centre on zero length
    h = 16'd127;
    send_pixel(16'd0, 16'd0, 16'd0);
    send_pixel(16'd255, 16'd255, 16'd255);
    send_pixel(h, h, h);
    send_pixel(16'd128, 16'd128, 16'd128);
    send_pixel(16'd255, h, h);
    send_pixel(16'd0, h, h);
    send_pixel(h, 16'd255, h);
    send_pixel(h, h, 16'd0);
    send_pixel(16'hffff, 16'hffff, 16'hffff);
    send_pixel(16'hffff, 16'd0, 16'h8000);
    send_pixel(16'd200, 16'd10, 16'd90);
    write_max(16'd1);
    send_pixel(16'd0, 16'd1, 16'd0);
    send_pixel(16'd1, 16'd1, 16'd1);
    send_pixel(16'hffff, 16'h5555, 16'haaaa);
    write_max(16'd0);
    send_pixel(16'd0, 16'd0, 16'd1);
    send_pixel(16'hffff, 16'hffff, 16'hffff);
    write_max(16'd2);
    send_pixel(16'd1, 16'd1, 16'd1);
    send_pixel(16'd1, 16'd2, 16'd0);
    write_max(16'd65535);
    send_pixel(16'd32767, 16'd32768, 16'd32767);
    send_pixel(16'hffff, 16'd0, 16'd1);
    send_pixel(16'h5555, 16'haaaa, 16'h0001);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      write_max(max_plan[phase]);
      for (int n = 0; n < 141; n++)
        send_pixel(pick_sample(active_max), pick_sample(active_max),
                   pick_sample(active_max));
    end

    pixel_ch.valid <= 1'b0;
    recv_stall_pct = 0;
    while (board.pending_normals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

// ----- normal_vector_decode_normalize.f -----
rtl/core/nvdn_pkg.sv
rtl/core/nvdn_ifs.sv
rtl/core/nvdn_phase.sv
rtl/core/nvdn_sine.sv
rtl/core/nvdn_norm_len.sv
rtl/core/nvdn_q15_div.sv
rtl/core/normal_vector_decode_normalize.sv
dv/normal_vector_decode_normalize_tb.sv
